[design/ssmi_pkg.sv]
// ---------------------------------------------------------------------------
// ssmi_pkg
// shared types and constants for the seasonal slot mean imputer
// ---------------------------------------------------------------------------
package ssmi_pkg;

  localparam int SLOTS     = 168;
  localparam int SERIES    = 64;
  localparam int TRAIN_LEN = 32768;

  localparam int VAL_W    = 20;
  localparam int SUM_W    = 35;
  localparam int CNT_W    = 16;
  localparam int SID_W    = 6;
  localparam int TIME_W   = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int DEPTH    = SERIES * SLOTS;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int QDEPTH   = 2;

  // time / 168 as ((time >> 3) * 3121) >> 16, exact for every 16-bit time
  localparam int SLOT_PRE   = 3;
  localparam int SLOT_RECIP = 3121;
  localparam int SLOT_RSH   = 16;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] SRC_PASS  = 2'd0;
  localparam logic [1:0] SRC_SLOT  = 2'd1;
  localparam logic [1:0] SRC_SER   = 2'd2;
  localparam logic [1:0] SRC_NONE  = 2'd3;

  // classified word handed from front to back
  typedef struct packed {
    logic              op;
    logic              missing;
    logic              series_ok;
    logic              time_ok;
    logic [SID_W-1:0]  sid;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

[design/ssmi_front.sv]
// ---------------------------------------------------------------------------
// ssmi_front
// accepts words, works out the slot index and range checks, fills the queue
// ---------------------------------------------------------------------------
module ssmi_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [ssmi_pkg::SID_W-1:0] in_series_id,
  input  logic [ssmi_pkg::TIME_W-1:0] in_time_index,
  input  logic [ssmi_pkg::VAL_W-1:0] in_sample_value,
  input  logic                       in_sample_missing,
  output logic                       q_valid,
  output ssmi_pkg::cmd_t             q_cmd,
  input  logic                       q_pop
);
  import ssmi_pkg::*;

  cmd_t             q_mem_r [QDEPTH];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic             push;
  cmd_t             c;
  logic [TIME_W-SLOT_PRE-1:0]  t_hi;
  logic [TIME_W-SLOT_PRE+11:0] q_prod;
  logic [8:0]        t_div;
  logic [TIME_W-1:0] slot_full;
  logic [SLOT_W-1:0] slot;
  logic             sok;

  assign busy    = (cnt_r == 2'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_mem_r[rp_r];

  // slot = time mod 168 through a reciprocal multiply
  assign t_hi      = in_time_index[TIME_W-1:SLOT_PRE];
  assign q_prod    = t_hi * 12'(SLOT_RECIP);
  assign t_div     = q_prod[SLOT_RSH+8:SLOT_RSH];
  assign slot_full = in_time_index - TIME_W'(32'(t_div) * SLOTS);
  assign slot      = slot_full[SLOT_W-1:0];
  assign sok       = (32'(in_series_id) < 32'(SERIES));

  always_comb begin
    c.op        = in_operation;
    c.missing   = in_sample_missing;
    c.series_ok = sok;
    c.time_ok   = (32'(in_time_index) < 32'(TRAIN_LEN));
    c.sid       = in_series_id;
    c.idx       = sok ? IDX_W'(32'(in_series_id) * SLOTS + 32'(slot)) : '0;
    c.value     = in_sample_value;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
    if (push) q_mem_r[wp_r] <= c;
  end

endmodule

[design/ssmi_div.sv]
// ---------------------------------------------------------------------------
// ssmi_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ssmi_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ssmi_pkg::SUM_W-1:0] dividend,
  input  logic [ssmi_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [ssmi_pkg::VAL_W-1:0] quotient
);
  import ssmi_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt, done_nxt;
  logic [CNT_W:0]    trial;

  assign quotient = q_r[VAL_W-1:0];

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CNT_W-1:0], q_r[SUM_W-1]};
    if (go) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(SUM_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done   <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (go) dvs_r <= divisor;
  end

endmodule

[design/ssmi_back.sv]
// ---------------------------------------------------------------------------
// ssmi_back
// executes train and fill commands against the slot and series tables
// ---------------------------------------------------------------------------
module ssmi_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  ssmi_pkg::cmd_t             q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic [ssmi_pkg::VAL_W-1:0] out_filled_value,
  output logic [1:0]                 out_fill_source
);
  import ssmi_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  logic [SUM_W+CNT_W-1:0] slot_mem [DEPTH];
  logic [SUM_W+CNT_W-1:0] ser_mem  [SERIES];
  logic [SUM_W+CNT_W-1:0] slot_rd_r, ser_rd_r;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W:0]   clr_r, clr_nxt;
  cmd_t             cmd_r;
  logic [1:0]       src_r;

  logic [SUM_W-1:0] ss, rs;
  logic [CNT_W-1:0] sc, rc;
  logic [SUM_W:0]   ss_add, rs_add;
  logic             tr_ok, wr;
  logic             div_go, div_done;
  logic [SUM_W-1:0] div_a;
  logic [CNT_W-1:0] div_b;
  logic [VAL_W-1:0] div_q;

  assign {ss, sc} = slot_rd_r;
  assign {rs, rc} = ser_rd_r;
  assign ss_add = {1'b0, ss} + (SUM_W+1)'(cmd_r.value);
  assign rs_add = {1'b0, rs} + (SUM_W+1)'(cmd_r.value);
  assign tr_ok  = !cmd_r.missing && cmd_r.series_ok && cmd_r.time_ok &&
                  sc != COUNT_MAX && rc != COUNT_MAX &&
                  !ss_add[SUM_W] && !rs_add[SUM_W];

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign wr    = (state_r == S_EXEC) && !cmd_r.op && tr_ok;
  assign div_go = (state_r == S_EXEC) && cmd_r.op && cmd_r.missing &&
                  cmd_r.series_ok && rc != '0;
  assign div_a = (sc != '0) ? ss : rs;
  assign div_b = (sc != '0) ? sc : rc;

  ssmi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IDX_W+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (q_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: state_nxt = div_go ? S_DIV : S_IDLE;
      S_DIV:  if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      out_valid <= ((state_r == S_EXEC) && cmd_r.op && !div_go) ||
                   ((state_r == S_DIV) && div_done);
    end
    if (q_pop) cmd_r <= q_cmd;
    if (state_r == S_CLR) begin
      slot_mem[clr_r[IDX_W-1:0]] <= '0;
      if (clr_r < (IDX_W+1)'(SERIES)) ser_mem[clr_r[SID_W-1:0]] <= '0;
    end else if (wr) begin
      slot_mem[cmd_r.idx] <= {ss_add[SUM_W-1:0], sc + 1'b1};
      ser_mem[cmd_r.sid]  <= {rs_add[SUM_W-1:0], rc + 1'b1};
    end
    if (state_r == S_RD) begin
      slot_rd_r <= slot_mem[cmd_r.idx];
      ser_rd_r  <= ser_mem[cmd_r.sid];
    end
    if (state_r == S_EXEC) begin
      if (!cmd_r.missing) begin
        out_filled_value <= cmd_r.value;
        out_fill_source  <= SRC_PASS;
      end else if (!cmd_r.series_ok || rc == '0) begin
        out_filled_value <= '0;
        out_fill_source  <= SRC_NONE;
      end
      src_r <= (sc != '0) ? SRC_SLOT : SRC_SER;
    end
    if (state_r == S_DIV && div_done) begin
      out_filled_value <= div_q;
      out_fill_source  <= src_r;
    end
  end

endmodule

[design/seasonal_slot_mean_imputer_core.sv]
// ---------------------------------------------------------------------------
// seasonal_slot_mean_imputer_core
// per-series hour-of-week mean imputation with train and fill commands
// ---------------------------------------------------------------------------
//  channel  | handshake         | ports
//  input    | start / busy      | in_operation .. in_sample_missing
//  result   | out_valid strobe  | out_filled_value, out_fill_source
//
// train word: the back end pops the queue, reads the tables, then updates them
// fill word: queue pop, table read, then a result, or a run of the 35-step divider when a mean is computed
// after reset a clearing pass over all 10752 slot entries zeroes the slot and series tables; the
// two-entry queue fills and busy rises until it ends
// results appear for one cycle on out_valid and cannot be stalled
module seasonal_slot_mean_imputer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [ssmi_pkg::SID_W-1:0]  in_series_id,
  input  logic [ssmi_pkg::TIME_W-1:0] in_time_index,
  input  logic [ssmi_pkg::VAL_W-1:0]  in_sample_value,
  input  logic                        in_sample_missing,
  output logic                        out_valid,
  output logic [ssmi_pkg::VAL_W-1:0]  out_filled_value,
  output logic [1:0]                  out_fill_source
);
  import ssmi_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  ssmi_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_series_id      (in_series_id),
    .in_time_index     (in_time_index),
    .in_sample_value   (in_sample_value),
    .in_sample_missing (in_sample_missing),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop)
  );

  ssmi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_filled_value (out_filled_value),
    .out_fill_source  (out_fill_source)
  );

endmodule

[design/ssmi_checker.sv]
// ---------------------------------------------------------------------------
// ssmi_checker
// port-level checks for the imputer core
// ---------------------------------------------------------------------------
module ssmi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [19:0] out_filled_value,
  input logic [1:0]  out_fill_source
);

  // no training data always reads as zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_source == 2'd3 |-> out_filled_value == '0)
    else $error("no-data fill gave nonzero value");

  // back end passes through idle, read and execute states per word, so strobes never come back to back
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two adjacent cycles");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

endmodule

bind seasonal_slot_mean_imputer_core ssmi_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_filled_value (out_filled_value),
  .out_fill_source  (out_fill_source)
);

[tb/tb_seasonal_slot_mean_imputer_core.sv]
// ---------------------------------------------------------------------------
// tb_seasonal_slot_mean_imputer_core
// self-checking bench: train and fill words against a slot mean predictor
// ---------------------------------------------------------------------------
// A driver block feeds the block from a queue of pending words. A monitor
// block checks every result strobe against the oldest predicted result.
// The driver idles at random.
module tb_seasonal_slot_mean_imputer_core;
  import ssmi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_FILL  = 1'b1;
  localparam int   WATCHDOG = 40000;

  typedef struct packed {
    logic              op;
    logic [SID_W-1:0]  sid;
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  value;
    logic              missing;
  } word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       source;
  } fill_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [SID_W-1:0]  in_series_id;
  logic [TIME_W-1:0] in_time_index;
  logic [VAL_W-1:0]  in_sample_value;
  logic              in_sample_missing;
  logic              out_valid;
  logic [VAL_W-1:0]  out_filled_value;
  logic [1:0]        out_fill_source;

  seasonal_slot_mean_imputer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_series_id     (in_series_id),
    .in_time_index    (in_time_index),
    .in_sample_value  (in_sample_value),
    .in_sample_missing(in_sample_missing),
    .out_valid        (out_valid),
    .out_filled_value (out_filled_value),
    .out_fill_source  (out_fill_source)
  );

  // predictor state
  logic [SUM_W-1:0] pred_slot_sum [DEPTH];
  logic [CNT_W-1:0] pred_slot_cnt [DEPTH];
  logic [SUM_W-1:0] pred_ser_sum [SERIES];
  logic [CNT_W-1:0] pred_ser_cnt [SERIES];

  word_t pending_words[$];
  fill_t expected_fills[$];
  int    mismatches = 0;
  int    fills_seen = 0;
  int    trains_sent = 0;
  int    idle_cycles = 0;
  logic  quiet;  // no random idling while set
  logic  hold;   // sender held off until all results are in

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // update predictor for one accepted word
  task automatic apply_word(input word_t w);
    int          slot;
    int          idx;
    logic        ser_ok;
    logic [SUM_W:0] ns, nq;
    fill_t       f;
    begin
      slot   = w.t % SLOTS;
      ser_ok = w.sid < SERIES;
      idx    = ser_ok ? w.sid * SLOTS + slot : 0;
      if (w.op == OP_TRAIN) begin
        trains_sent++;
        if (!w.missing && ser_ok && w.t < TRAIN_LEN &&
            pred_slot_cnt[idx] != COUNT_MAX && pred_ser_cnt[w.sid] != COUNT_MAX) begin
          ns = {1'b0, pred_slot_sum[idx]} + w.value;
          nq = {1'b0, pred_ser_sum[w.sid]} + w.value;
          if (!ns[SUM_W] && !nq[SUM_W]) begin
            pred_slot_sum[idx]   = ns[SUM_W-1:0];
            pred_slot_cnt[idx]   = pred_slot_cnt[idx] + 1'b1;
            pred_ser_sum[w.sid]  = nq[SUM_W-1:0];
            pred_ser_cnt[w.sid]  = pred_ser_cnt[w.sid] + 1'b1;
          end
        end
      end else begin
        if (!w.missing) begin
          f.value  = w.value;
          f.source = SRC_PASS;
        end else if (!ser_ok || pred_ser_cnt[w.sid] == '0) begin
          f.value  = '0;
          f.source = SRC_NONE;
        end else if (pred_slot_cnt[idx] != '0) begin
          f.value  = VAL_W'(pred_slot_sum[idx] / pred_slot_cnt[idx]);
          f.source = SRC_SLOT;
        end else begin
          f.value  = VAL_W'(pred_ser_sum[w.sid] / pred_ser_cnt[w.sid]);
          f.source = SRC_SER;
        end
        expected_fills.push_back(f);
      end
    end
  endtask

  function automatic word_t make_word(input logic op, input int sid, input int t,
                                      input int value, input logic missing);
    word_t w;
    w.op      = op;
    w.sid     = SID_W'(sid);
    w.t       = TIME_W'(t);
    w.value   = VAL_W'(value);
    w.missing = missing;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start             <= 1'b0;
      in_operation      <= OP_TRAIN;
      in_series_id      <= '0;
      in_time_index     <= '0;
      in_sample_value   <= '0;
      in_sample_missing <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_word({in_operation, in_series_id, in_time_index,
                    in_sample_value, in_sample_missing});
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (pending_words.size() != 0 && !hold &&
                   (quiet || $urandom_range(99) >= 20)) begin
        word_t w;
        w = pending_words.pop_front();
        start             <= 1'b1;
        in_operation      <= w.op;
        in_series_id      <= w.sid;
        in_time_index     <= w.t;
        in_sample_value   <= w.value;
        in_sample_missing <= w.missing;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG);
        $display("seasonal_slot_mean_imputer_core: mismatch");
        $finish;
      end
    end
    if (rst_n && out_valid) begin
      fills_seen++;
      if (expected_fills.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h source %0d",
                   out_filled_value, out_fill_source);
      end else begin
        fill_t f;
        f = expected_fills.pop_front();
        if (f.value !== out_filled_value || f.source !== out_fill_source) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected value %h source %0d, got value %h source %0d",
                     fills_seen, f.value, f.source, out_filled_value, out_fill_source);
        end
      end
    end
  end

  function automatic word_t rand_word();
    word_t w;
    int    r;
    r = $urandom_range(99);
    // mostly a few series and slots so means and slot hits build up
    w.op      = (r < 55) ? OP_TRAIN : OP_FILL;
    w.sid     = ($urandom_range(9) == 0) ? SID_W'($urandom) : SID_W'($urandom_range(3));
    w.t       = ($urandom_range(9) < 7) ? TIME_W'($urandom_range(5) + SLOTS * $urandom_range(150))
                                        : TIME_W'($urandom);
    w.value   = ($urandom_range(4) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(4095));
    w.missing = (w.op == OP_FILL) ? ($urandom_range(9) < 7) : ($urandom_range(9) == 0);
    return w;
  endfunction

  initial begin
    int i;
    foreach (pred_slot_sum[k]) begin
      pred_slot_sum[k] = '0;
      pred_slot_cnt[k] = '0;
    end
    foreach (pred_ser_sum[k]) begin
      pred_ser_sum[k] = '0;
      pred_ser_cnt[k] = '0;
    end
    rst_n = 1'b0; quiet = 1'b0; hold = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty series, pass through, extremes, ignored trains
    pending_words.push_back(make_word(OP_FILL, 0, 0, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 63, 65535, 1048575, 1'b0));
    pending_words.push_back(make_word(OP_FILL, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(OP_TRAIN, 5, 32768, 100, 1'b0));
    pending_words.push_back(make_word(OP_TRAIN, 5, 10, 100, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 5, 10, 0, 1'b1));
    pending_words.push_back(make_word(OP_TRAIN, 5, 10, 1048575, 1'b0));
    pending_words.push_back(make_word(OP_TRAIN, 5, 10 + SLOTS, 2, 1'b0));
    pending_words.push_back(make_word(OP_TRAIN, 5, 32767, 7, 1'b0));
    pending_words.push_back(make_word(OP_TRAIN, 63, 0, 0, 1'b0));
    pending_words.push_back(make_word(OP_FILL, 5, 10, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 5, 11, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 5, 65535, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 63, SLOTS, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 63, 1, 0, 1'b1));
    pending_words.push_back(make_word(OP_FILL, 42, 3, 12345, 1'b0));
    wait (pending_words.size() == 0);

    // hold off until every result is in
    hold <= 1'b1;
    @(posedge clk);
    while (start) @(posedge clk);
    wait (expected_fills.size() == 0);
    @(posedge clk);
    hold <= 1'b0;

    for (i = 0; i < 1000; i++) begin
      pending_words.push_back(rand_word());
      if (i == 300) quiet = 1'b1;
      if (i == 500) quiet = 1'b0;
      if (pending_words.size() > 20) wait (pending_words.size() < 10);
    end
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    wait (expected_fills.size() == 0);
    repeat (60) @(posedge clk);

    $display("covered %0d train words and %0d fill results across pass, slot, series and",
             trains_sent, fills_seen);
    $display("empty cases, with random sender gaps and an idle hold-off");
    if (mismatches == 0 && expected_fills.size() == 0) begin
      $display("seasonal_slot_mean_imputer_core: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("seasonal_slot_mean_imputer_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ssmi_pkg.sv
design/ssmi_front.sv
design/ssmi_div.sv
design/ssmi_back.sv
design/seasonal_slot_mean_imputer_core.sv
design/ssmi_checker.sv
tb/tb_seasonal_slot_mean_imputer_core.sv
